>>> hw/rtl/uvs_pkg.sv
// Shared widths, constants and types of the UV sphere vertex generator.
package uvs_pkg;

  localparam int IDX_W = 10;  // cell index width
  localparam int CNT_W = 11;  // stack / sector count width
  localparam int PH_W  = 32;  // angle phase, 2^-32 turn
  localparam int SC_W  = 32;  // signed Q30 sine / cosine
  localparam int TEX_W = 16;
  localparam int POS_W = 17;
  localparam int NRM_W = 16;
  localparam int RAD_W = 16;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Per-vertex data that rides along the arithmetic pipeline
  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             last;
  } uvs_side_t;

endpackage

>>> hw/rtl/uv_sphere_cell_vertex_generator.sv
// Top level: cell request sequencer, configuration registers and the vertex pipeline.
//
// A cell request (stack and sector index) is taken at a clock edge with start high
// and busy low. The cell produces six vertices p1,p2,p3,p3,p4,p2, one per cycle,
// each shown for one cycle with out_valid; the sixth carries out_last_vertex.
// Indices beyond the counts saturate to count minus one.
// On its way out each vertex passes from the issue cycle into the first of 8 divider
// stages (4 quotient bits each), then 17 sine / cosine stages (angle, square, Horner
// products and constant divides, quadrant) and 2 output stages. busy stays high in
// all but the last of the sequencer's six issue slots, so the next cell can be taken
// in that last slot and, while start stays high, the vertex stream runs without gaps.
// The receiver cannot hold results off, so the pipeline never stalls.
// Configuration writes (radius, sector count, stack count) complete on a cycle with
// cfg_valid and cfg_ready high; cfg_ready is low while start is high and until the
// last vertex of the previous cell has left the pipeline.
// Reset restores radius 256, 36 sectors and 18 stacks and empties the pipeline.
module uv_sphere_cell_vertex_generator #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [uvs_pkg::IDX_W-1:0]          in_stack_index,
  input  logic [uvs_pkg::IDX_W-1:0]          in_sector_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [uvs_pkg::RAD_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic signed [uvs_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]   out_pos_z,
  output logic signed [uvs_pkg::NRM_W-1:0]   out_norm_x,
  output logic signed [uvs_pkg::NRM_W-1:0]   out_norm_y,
  output logic signed [uvs_pkg::NRM_W-1:0]   out_norm_z,
  output logic [uvs_pkg::TEX_W-1:0]          out_tex_u,
  output logic [uvs_pkg::TEX_W-1:0]          out_tex_v,
  output logic                               out_last_vertex
);
  import uvs_pkg::*;

  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_STACKS  = 2'd2;
  localparam logic [2:0] LAST_SLOT   = 3'd5;
  localparam logic [4:0] FLIGHT_CYCLES = 5'd27;  // issue to last vertex out

  // row / column offsets of the six vertices
  localparam logic DI [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam logic DJ [6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (32'(v) > MAX_SEGMENTS) return CNT_W'(MAX_SEGMENTS);
    return v;
  endfunction

  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] sector_total_r;
  logic [CNT_W-1:0] stack_total_r;
  logic             active_r;
  logic [2:0]       cnt_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic [4:0]       flight_r;

  logic [CNT_W-1:0] stacks;
  logic [CNT_W-1:0] sectors;
  logic [IDX_W-1:0] sat_row;
  logic [IDX_W-1:0] sat_col;
  logic             req_take;
  logic [CNT_W-1:0] k_row;
  logic [CNT_W-1:0] k_col;

  logic                    div_valid;
  logic [1:0][PH_W-1:0]    div_phase;
  uvs_side_t               div_side;
  logic                    sc_valid;
  logic [1:0][SC_W-1:0]    sc_sin;
  logic [1:0][SC_W-1:0]    sc_cos;
  uvs_side_t               sc_side;
  logic [2:0][POS_W-1:0]   vx_pos;
  logic [2:0][NRM_W-1:0]   vx_norm;
  uvs_side_t               vx_side;

  assign stacks    = eff_count(stack_total_r);
  assign sectors   = eff_count(sector_total_r);
  assign busy      = active_r && (cnt_r != LAST_SLOT);
  assign req_take  = start && !busy;
  assign cfg_ready = !start && !active_r && (flight_r == 5'd0);

  // index saturation
  assign sat_row = ({1'b0, in_stack_index} >= stacks) ?
                   IDX_W'(stacks - CNT_W'(1)) : in_stack_index;
  assign sat_col = ({1'b0, in_sector_index} >= sectors) ?
                   IDX_W'(sectors - CNT_W'(1)) : in_sector_index;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= RAD_W'(256);
      sector_total_r <= CNT_W'(36);
      stack_total_r  <= CNT_W'(18);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS:  radius_r       <= cfg_data;
        REG_SECTORS: sector_total_r <= cfg_data[CNT_W-1:0];
        REG_STACKS:  stack_total_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // in-flight countdown: configuration waits until the pipeline is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else if (active_r) begin
      flight_r <= FLIGHT_CYCLES;
    end else if (flight_r != 5'd0) begin
      flight_r <= flight_r - 5'd1;
    end
  end

  // vertex issue sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (req_take) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (cnt_r == LAST_SLOT) active_r <= 1'b0;
      else                    cnt_r    <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      row_r <= sat_row;
      col_r <= sat_col;
    end
  end

  assign k_row = {1'b0, row_r} + CNT_W'(DI[cnt_r]);
  assign k_col = {1'b0, col_r} + CNT_W'(DJ[cnt_r]);

  uvs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (active_r),
    .in_k      ({k_col, k_row}),
    .in_n      ({sectors, stacks}),
    .in_last   (cnt_r == LAST_SLOT),
    .out_valid (div_valid),
    .out_phase (div_phase),
    .out_side  (div_side)
  );

  uvs_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_phase  (div_phase),
    .in_side   (div_side),
    .out_valid (sc_valid),
    .out_sin   (sc_sin),
    .out_cos   (sc_cos),
    .out_side  (sc_side)
  );

  uvs_vtx u_vtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_sin    (sc_sin),
    .in_cos    (sc_cos),
    .in_side   (sc_side),
    .radius    (radius_r),
    .out_valid (out_valid),
    .out_pos   (vx_pos),
    .out_norm  (vx_norm),
    .out_side  (vx_side)
  );

  assign out_pos_x       = $signed(vx_pos[0]);
  assign out_pos_y       = $signed(vx_pos[1]);
  assign out_pos_z       = $signed(vx_pos[2]);
  assign out_norm_x      = $signed(vx_norm[0]);
  assign out_norm_y      = $signed(vx_norm[1]);
  assign out_norm_z      = $signed(vx_norm[2]);
  assign out_tex_u       = vx_side.tex_u;
  assign out_tex_v       = vx_side.tex_v;
  assign out_last_vertex = vx_side.last;

  // sequencer checks
  a_take_starts_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> (active_r && cnt_r == 3'd0))
    else $error("accepted request did not start at vertex slot 0");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r <= LAST_SLOT))
    else $error("vertex slot counter out of range");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r == LAST_SLOT && !start) |=> !active_r)
    else $error("sequencer kept issuing after the last vertex");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (!active_r && !out_valid))
    else $error("configuration write while a cell was in flight");

endmodule

>>> hw/rtl/uvs_div.sv
// Pipelined restoring divider: angle phases and texture coordinates from row and column.
module uvs_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [1:0][uvs_pkg::CNT_W-1:0]   in_k,      // lane 0 stack row, lane 1 sector column
  input  logic [1:0][uvs_pkg::CNT_W-1:0]   in_n,      // effective counts, stable while busy
  input  logic                             in_last,
  output logic                             out_valid,
  output logic [1:0][uvs_pkg::PH_W-1:0]    out_phase,
  output uvs_pkg::uvs_side_t               out_side
);
  import uvs_pkg::*;

  localparam int STAGES    = 8;
  localparam int STEPS     = 4;   // quotient bits per stage
  localparam int TEX_STEPS = 15;  // k*2^15/n for the Q1.15 texture coordinate

  logic [CNT_W-1:0] rem_r   [2][STAGES];
  logic [CNT_W-1:0] rem_nxt [2][STAGES];
  logic [PH_W:0]    quo_r   [2][STAGES];
  logic [PH_W:0]    quo_nxt [2][STAGES];
  logic [TEX_W-1:0] tex_r   [2][STAGES];
  logic [TEX_W-1:0] tex_nxt [2][STAGES];
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] last_r;

  // Quotient bits of k*2^31/n (polar) and k*2^32/n (azimuth), STEPS per stage
  always_comb begin
    logic [CNT_W:0]   rr;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] rem;
    logic [PH_W:0]    quo;
    logic [TEX_W-1:0] tex;
    for (int l = 0; l < 2; l++) begin
      for (int g = 0; g < STAGES; g++) begin
        if (g == 0) begin
          // integer part is 1 only when k equals n
          if (in_k[l] >= in_n[l]) begin
            rem = in_k[l] - in_n[l];
            quo = (PH_W+1)'(1);
          end else begin
            rem = in_k[l];
            quo = '0;
          end
          tex = '0;
        end else begin
          rem = rem_r[l][g-1];
          quo = quo_r[l][g-1];
          tex = tex_r[l][g-1];
        end
        for (int t = 0; t < STEPS; t++) begin
          if (g * STEPS + t < PH_W - 1 + l) begin
            rr = {rem, 1'b0};
            if (rr >= {1'b0, in_n[l]}) begin
              rr  = rr - {1'b0, in_n[l]};
              quo = {quo[PH_W-1:0], 1'b1};
            end else begin
              quo = {quo[PH_W-1:0], 1'b0};
            end
            rem = rr[CNT_W-1:0];
            if (g * STEPS + t == TEX_STEPS - 1) begin
              // round half up: remainder plus n/2 reaching n
              sum = {1'b0, rem} + {1'b0, in_n[l] >> 1};
              tex = quo[TEX_W-1:0] + TEX_W'(sum >= {1'b0, in_n[l]});
            end
          end
        end
        rem_nxt[l][g] = rem;
        quo_nxt[l][g] = quo;
        tex_nxt[l][g] = tex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[STAGES-2:0], in_last};
    for (int l = 0; l < 2; l++) begin
      for (int g = 0; g < STAGES; g++) begin
        rem_r[l][g] <= rem_nxt[l][g];
        quo_r[l][g] <= quo_nxt[l][g];
        tex_r[l][g] <= tex_nxt[l][g];
      end
    end
  end

  assign out_valid    = vld_r[STAGES-1];
  assign out_phase[0] = quo_r[0][STAGES-1][PH_W-1:0];
  assign out_phase[1] = quo_r[1][STAGES-1][PH_W-1:0];
  assign out_side     = '{tex_u: tex_r[1][STAGES-1],
                          tex_v: tex_r[0][STAGES-1],
                          last:  last_r[STAGES-1]};

endmodule

>>> hw/rtl/uvs_sincos.sv
// Pipelined Q30 sine and cosine of two phases, Taylor series in Horner form.
module uvs_sincos (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [1:0][uvs_pkg::PH_W-1:0]  in_phase,
  input  uvs_pkg::uvs_side_t             in_side,
  output logic                           out_valid,
  output logic [1:0][uvs_pkg::SC_W-1:0]  out_sin,
  output logic [1:0][uvs_pkg::SC_W-1:0]  out_cos,
  output uvs_pkg::uvs_side_t             out_side
);
  import uvs_pkg::*;

  // stage 0: angle, stage 1: square, 2..15: Horner mult/divide pairs, 16: quadrant
  localparam int STAGES    = 17;
  localparam int SEL_STAGE = 16;
  localparam int SIN_FINAL = 6;   // step where sine multiplies by x
  localparam logic [30:0] HALF_PI = 31'd1686629713;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // floor(v/d) = (v*M) >> (32+ceil(log2 d)) for 32-bit v
  localparam logic [32:0] SIN_MAG [7] = '{
    33'((64'd1 << 40) / 156 + 1), 33'((64'd1 << 39) / 110 + 1),
    33'((64'd1 << 39) / 72 + 1),  33'((64'd1 << 38) / 42 + 1),
    33'((64'd1 << 37) / 20 + 1),  33'((64'd1 << 35) / 6 + 1), 33'd0};
  localparam int SIN_SH [7] = '{40, 39, 39, 38, 37, 35, 0};
  localparam logic [32:0] COS_MAG [7] = '{
    33'((64'd1 << 40) / 182 + 1), 33'((64'd1 << 40) / 132 + 1),
    33'((64'd1 << 39) / 90 + 1),  33'((64'd1 << 38) / 56 + 1),
    33'((64'd1 << 37) / 30 + 1),  33'((64'd1 << 36) / 12 + 1),
    33'((64'd1 << 33) / 2 + 1)};
  localparam int COS_SH [7] = '{40, 40, 39, 38, 37, 36, 33};

  logic [30:0] x_r    [2][STAGES];
  logic [30:0] x_nxt  [2][STAGES];
  logic [31:0] x2_r   [2][STAGES];
  logic [31:0] x2_nxt [2][STAGES];
  logic [1:0]  qd_r   [2][STAGES];
  logic [1:0]  qd_nxt [2][STAGES];
  logic [31:0] vs_r   [2][STAGES];
  logic [31:0] vs_nxt [2][STAGES];
  logic [31:0] vc_r   [2][STAGES];
  logic [31:0] vc_nxt [2][STAGES];
  logic [STAGES-1:0] vld_r;
  uvs_side_t side_r [STAGES];

  always_comb begin
    logic [30:0] x;
    logic [31:0] x2;
    logic [1:0]  qd;
    logic [31:0] vs;
    logic [31:0] vc;
    logic [31:0] ts;
    logic [31:0] tc;
    logic [60:0] pr0;
    logic [61:0] pr1;
    logic [62:0] ps;
    logic [62:0] pc;
    logic [64:0] ds;
    logic [64:0] dc;
    int          step;
    for (int a = 0; a < 2; a++) begin
      for (int s = 0; s < STAGES; s++) begin
        step = (s - 2) >> 1;
        if (s == 0) begin
          x  = '0;
          x2 = '0;
          qd = in_phase[a][PH_W-1:PH_W-2];
          vs = '0;
          vc = '0;
        end else begin
          x  = x_r[a][s-1];
          x2 = x2_r[a][s-1];
          qd = qd_r[a][s-1];
          vs = vs_r[a][s-1];
          vc = vc_r[a][s-1];
        end
        if (s == 0) begin
          // low 30 phase bits to radians in Q30
          pr0 = in_phase[a][PH_W-3:0] * HALF_PI;
          x   = pr0[60:30];
        end else if (s == 1) begin
          pr1 = x * x;
          x2  = pr1[61:30];
          vs  = 32'(Q30_ONE);
          vc  = 32'(Q30_ONE);
        end else if (s < SEL_STAGE) begin
          if (((s - 2) & 1) == 0) begin
            // Horner product
            if (step == SIN_FINAL) ps = x * vs[30:0];
            else                   ps = x2 * vs[30:0];
            pc = x2 * vc[30:0];
            vs = ps[61:30];
            vc = pc[61:30];
          end else begin
            // divide by constant, 1 - q clamped at 0; last sine step clamps to one
            if (step == SIN_FINAL) begin
              vs = (vs > 32'(Q30_ONE)) ? 32'(Q30_ONE) : vs;
            end else begin
              ds = vs * SIN_MAG[step];
              ts = 32'(ds >> SIN_SH[step]);
              vs = (ts > 32'(Q30_ONE)) ? '0 : 32'(Q30_ONE) - ts;
            end
            dc = vc * COS_MAG[step];
            tc = 32'(dc >> COS_SH[step]);
            vc = (tc > 32'(Q30_ONE)) ? '0 : 32'(Q30_ONE) - tc;
          end
        end else begin
          // quadrant mapping
          ts = vs;
          tc = vc;
          case (qd)
            QUAD_I:   begin vs = ts;         vc = tc;         end
            QUAD_II:  begin vs = tc;         vc = 32'd0 - ts; end
            QUAD_III: begin vs = 32'd0 - ts; vc = 32'd0 - tc; end
            QUAD_IV:  begin vs = 32'd0 - tc; vc = ts;         end
            default:  begin vs = ts;         vc = tc;         end
          endcase
        end
        x_nxt[a][s]  = x;
        x2_nxt[a][s] = x2;
        qd_nxt[a][s] = qd;
        vs_nxt[a][s] = vs;
        vc_nxt[a][s] = vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s < STAGES; s++) begin
      side_r[s] <= side_r[s-1];
    end
    for (int a = 0; a < 2; a++) begin
      for (int s = 0; s < STAGES; s++) begin
        x_r[a][s]  <= x_nxt[a][s];
        x2_r[a][s] <= x2_nxt[a][s];
        qd_r[a][s] <= qd_nxt[a][s];
        vs_r[a][s] <= vs_nxt[a][s];
        vc_r[a][s] <= vc_nxt[a][s];
      end
    end
  end

  assign out_valid  = vld_r[STAGES-1];
  assign out_sin[0] = vs_r[0][STAGES-1];
  assign out_sin[1] = vs_r[1][STAGES-1];
  assign out_cos[0] = vc_r[0][STAGES-1];
  assign out_cos[1] = vc_r[1][STAGES-1];
  assign out_side   = side_r[STAGES-1];

endmodule

>>> hw/rtl/uvs_vtx.sv
// Direction, scaled position and Q2.14 normal from polar and azimuth sine / cosine.
module uvs_vtx (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0][uvs_pkg::SC_W-1:0]   in_sin,   // 0 polar, 1 azimuth
  input  logic [1:0][uvs_pkg::SC_W-1:0]   in_cos,
  input  uvs_pkg::uvs_side_t              in_side,
  input  logic [uvs_pkg::RAD_W-1:0]       radius,
  output logic                            out_valid,
  output logic [2:0][uvs_pkg::POS_W-1:0]  out_pos,
  output logic [2:0][uvs_pkg::NRM_W-1:0]  out_norm,
  output uvs_pkg::uvs_side_t              out_side
);
  import uvs_pkg::*;

  localparam logic [61:0] RND30 = 62'd1 << 29;
  localparam logic [31:0] RND16 = 32'd1 << 15;

  function automatic logic [SC_W-1:0] magn(input logic [SC_W-1:0] v);
    return v[SC_W-1] ? SC_W'(0) - v : v;
  endfunction

  logic [SC_W-1:0]  d_r    [3];
  logic [SC_W-1:0]  d_nxt  [3];
  logic [POS_W-1:0] pos_r  [3];
  logic [POS_W-1:0] pos_nxt[3];
  logic [NRM_W-1:0] nrm_r  [3];
  logic [NRM_W-1:0] nrm_nxt[3];
  logic [1:0]       vld_r;
  uvs_side_t        side_r [2];

  // Stage 1: sin(polar) times cos / sin(azimuth), rounded half away from zero, and cos(polar)
  always_comb begin
    logic [SC_W-1:0] b;
    logic [SC_W-1:0] ma;
    logic [SC_W-1:0] mb;
    logic [61:0]     prod;
    logic [SC_W-1:0] p;
    for (int n = 0; n < 2; n++) begin
      b    = (n == 0) ? in_cos[1] : in_sin[1];
      ma   = magn(in_sin[0]);
      mb   = magn(b);
      prod = ma[30:0] * mb[30:0] + RND30;
      p    = prod[61:30];
      d_nxt[n] = (in_sin[0][SC_W-1] ^ b[SC_W-1]) ? SC_W'(0) - p : p;
    end
    d_nxt[2] = in_cos[0];
  end

  // Stage 2: radius scaling and Q30 to Q14
  always_comb begin
    logic [SC_W-1:0]  md;
    logic [46:0]      pp;
    logic [POS_W-1:0] p;
    logic [31:0]      nn;
    logic [NRM_W-1:0] q;
    for (int n = 0; n < 3; n++) begin
      md = magn(d_r[n]);
      pp = radius * md[30:0] + 47'(RND30);
      p  = pp[46:30];
      nn = md + RND16;
      q  = nn[31:16];
      pos_nxt[n] = d_r[n][SC_W-1] ? POS_W'(0) - p : p;
      nrm_nxt[n] = d_r[n][SC_W-1] ? NRM_W'(0) - q : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    side_r[1] <= side_r[0];
    for (int n = 0; n < 3; n++) begin
      d_r[n]   <= d_nxt[n];
      pos_r[n] <= pos_nxt[n];
      nrm_r[n] <= nrm_nxt[n];
    end
  end

  assign out_valid = vld_r[1];
  assign out_side  = side_r[1];
  assign out_pos   = {pos_r[2], pos_r[1], pos_r[0]};
  assign out_norm  = {nrm_r[2], nrm_r[1], nrm_r[0]};

endmodule

>>> test/tb_top.sv
// Testbench for the UV sphere cell vertex generator: random cells against a vertex predictor.
`timescale 1ns / 1ps

module tb_top;
  import uvs_pkg::*;

  localparam int MAX_SEG = 1024;
  localparam longint Q_ONE = 64'sd1 << 30;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam int DRAIN_CYCLES = 40;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_SECTORS = 2'd1,
    REG_STACKS = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] stack_idx;
    logic [IDX_W-1:0] sector_idx;
  } cell_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] in_stack_index = '0;
  logic [IDX_W-1:0] in_sector_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [RAD_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [NRM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic out_last_vertex;

  // Shadow copy of the configuration registers
  logic [RAD_W-1:0] radius_reg = 16'd256;
  logic [CNT_W-1:0] sectors_reg = 11'd36;
  logic [CNT_W-1:0] stacks_reg = 11'd18;

  cell_req_t pending_cells[$];
  vertex_t   expected_vertices[$];
  bit        calm = 1'b0;
  bit        failed = 1'b0;
  int        gap = 0;

  uv_sphere_cell_vertex_generator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_stack_index(in_stack_index), .in_sector_index(in_sector_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v), .out_last_vertex(out_last_vertex)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Effective count: 0 acts as 1, large counts clip to the segment limit
  function automatic int unsigned clip_count(logic [CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_SEG) return MAX_SEG;
    return n;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v < 0) return 0;
    if (v > Q_ONE) return Q_ONE;
    return v;
  endfunction

  // Round half away from zero of a*b / 2^sh
  function automatic longint round_mul(longint a, longint b, int sh);
    bit neg;
    longint unsigned ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = (ua * ub + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // Sine and cosine in Q30 of a phase in 2^-32 turn
  function automatic void phase_sincos(logic [31:0] ph, output longint s,
                                       output longint c);
    longint sden[6] = '{156, 110, 72, 42, 20, 6};
    longint cden[7] = '{182, 132, 90, 56, 30, 12, 2};
    longint x, x2, t, qs, qc;
    longint unsigned r;
    r = ph[29:0];
    x = longint'((r * longint'(HALF_PI)) >> 30);
    x2 = (x * x) >>> 30;
    t = Q_ONE;
    for (int k = 0; k < 6; k++) t = clamp_q30(Q_ONE - ((x2 * t) >>> 30) / sden[k]);
    qs = clamp_q30((x * t) >>> 30);
    t = Q_ONE;
    for (int k = 0; k < 7; k++) t = clamp_q30(Q_ONE - ((x2 * t) >>> 30) / cden[k]);
    qc = t;
    case (ph[31:30])
      2'd0: begin s = qs; c = qc; end
      2'd1: begin s = qc; c = -qs; end
      2'd2: begin s = -qs; c = -qc; end
      default: begin s = -qc; c = qs; end
    endcase
  endfunction

  // One vertex at grid point (k, m)
  function automatic vertex_t grid_vertex(int unsigned k, int unsigned m,
                                          int unsigned stacks, int unsigned sectors,
                                          bit last);
    vertex_t v;
    logic [31:0] pph, aph;
    longint sp, cp, sa, ca;
    longint d[3];
    longint p[3], q[3];
    pph = 32'((longint'(k) << 31) / stacks);
    aph = 32'((longint'(m) << 32) / sectors);
    phase_sincos(pph, sp, cp);
    phase_sincos(aph, sa, ca);
    d[0] = round_mul(sp, ca, 30);
    d[1] = round_mul(sp, sa, 30);
    d[2] = cp;
    for (int n = 0; n < 3; n++) begin
      p[n] = round_mul(longint'(radius_reg), d[n], 30);
      q[n] = round_mul(d[n], 1, 16);
    end
    v.pos_x = p[0][POS_W-1:0];
    v.pos_y = p[1][POS_W-1:0];
    v.pos_z = p[2][POS_W-1:0];
    v.norm_x = q[0][NRM_W-1:0];
    v.norm_y = q[1][NRM_W-1:0];
    v.norm_z = q[2][NRM_W-1:0];
    v.tex_u = 16'((longint'(m) * 32768 + sectors / 2) / sectors);
    v.tex_v = 16'((longint'(k) * 32768 + stacks / 2) / stacks);
    v.last = last;
    return v;
  endfunction

  // Queue the six vertices of a cell: p1,p2,p3,p3,p4,p2
  function automatic void predict_cell(cell_req_t c);
    int unsigned di[6] = '{0, 1, 0, 0, 1, 1};
    int unsigned dj[6] = '{0, 0, 1, 1, 1, 0};
    int unsigned stacks, sectors, i, j;
    stacks = clip_count(stacks_reg);
    sectors = clip_count(sectors_reg);
    i = c.stack_idx;
    j = c.sector_idx;
    if (i >= stacks) i = stacks - 1;
    if (j >= sectors) j = sectors - 1;
    for (int v = 0; v < 6; v++)
      expected_vertices.push_back(grid_vertex(i + di[v], j + dj[v], stacks, sectors, v == 5));
  endfunction

  // Driver: present pending cells, with random idle bursts
  always @(posedge clk) begin
    bit hold;
    cell_req_t c;
    if (start && !busy) predict_cell('{in_stack_index, in_sector_index});
    hold = start && busy;
    if (rst_n && !hold) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        c = pending_cells.pop_front();
        in_stack_index <= c.stack_idx;
        in_sector_index <= c.sector_idx;
        start <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) gap <= $urandom_range(1, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each vertex with the oldest expectation
  always @(posedge clk) begin
    vertex_t got, exp_v;
    if (rst_n && out_valid) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
              out_tex_u, out_tex_v, out_last_vertex};
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        failed = 1'b1;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got.pos_x !== exp_v.pos_x)
          $display("%0t: pos_x exp %0d got %0d", $time, exp_v.pos_x, got.pos_x);
        if (got.pos_y !== exp_v.pos_y)
          $display("%0t: pos_y exp %0d got %0d", $time, exp_v.pos_y, got.pos_y);
        if (got.pos_z !== exp_v.pos_z)
          $display("%0t: pos_z exp %0d got %0d", $time, exp_v.pos_z, got.pos_z);
        if (got.norm_x !== exp_v.norm_x)
          $display("%0t: norm_x exp %0d got %0d", $time, exp_v.norm_x, got.norm_x);
        if (got.norm_y !== exp_v.norm_y)
          $display("%0t: norm_y exp %0d got %0d", $time, exp_v.norm_y, got.norm_y);
        if (got.norm_z !== exp_v.norm_z)
          $display("%0t: norm_z exp %0d got %0d", $time, exp_v.norm_z, got.norm_z);
        if (got.tex_u !== exp_v.tex_u)
          $display("%0t: tex_u exp %0d got %0d", $time, exp_v.tex_u, got.tex_u);
        if (got.tex_v !== exp_v.tex_v)
          $display("%0t: tex_v exp %0d got %0d", $time, exp_v.tex_v, got.tex_v);
        if (got.last !== exp_v.last)
          $display("%0t: last exp %0b got %0b", $time, exp_v.last, got.last);
        if (got !== exp_v) failed = 1'b1;
      end
    end
  end

  // Register write over the configuration channel; shadow updated on accept
  task automatic write_reg(reg_idx_e idx, logic [RAD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS: radius_reg = data;
      REG_SECTORS: sectors_reg = data[CNT_W-1:0];
      REG_STACKS: stacks_reg = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued cell has gone out and the pipeline has drained
  task automatic drain();
    while (pending_cells.size() > 0 || start || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random cells: mostly inside the grid, some with any index
  task automatic add_random(int n);
    int unsigned st, se;
    cell_req_t c;
    st = clip_count(stacks_reg);
    se = clip_count(sectors_reg);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        c.stack_idx = $urandom_range(0, 1023);
        c.sector_idx = $urandom_range(0, 1023);
      end else begin
        c.stack_idx = $urandom_range(0, st - 1);
        c.sector_idx = $urandom_range(0, se - 1);
      end
      pending_cells.push_back(c);
    end
  endtask

  task automatic add_corners();
    int unsigned st, se;
    st = clip_count(stacks_reg);
    se = clip_count(sectors_reg);
    pending_cells.push_back('{10'd0, 10'd0});
    pending_cells.push_back('{10'(st - 1), 10'(se - 1)});
    pending_cells.push_back('{10'd1023, 10'd1023});
    pending_cells.push_back('{10'd0, 10'd1023});
    pending_cells.push_back('{10'd1023, 10'd0});
  endtask

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: poles, seam, saturated indices
    add_corners();
    pending_cells.push_back('{10'd9, 10'd18});
    pending_cells.push_back('{10'd17, 10'd35});
    pending_cells.push_back('{10'd18, 10'd36});
    pending_cells.push_back('{10'd4, 10'd9});
    add_random(30);
    drain();

    // Largest radius and counts
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_SECTORS, 16'd1024);
    write_reg(REG_STACKS, 16'd1024);
    add_corners();
    add_random(35);
    drain();

    // Zero radius, zero counts act as one, unknown index ignored
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_SECTORS, 16'd0);
    write_reg(REG_STACKS, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    add_corners();
    add_random(15);
    drain();

    // Tiny grid
    write_reg(REG_RADIUS, 16'($urandom_range(1, 65535)));
    write_reg(REG_SECTORS, 16'd3);
    write_reg(REG_STACKS, 16'd2);
    add_corners();
    add_random(35);
    drain();

    // Counts above the segment limit, upper cfg data bits set
    write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
    write_reg(REG_SECTORS, 16'hF7FF);
    write_reg(REG_STACKS, 16'd1500);
    add_corners();
    add_random(45);
    drain();

    // Random mid-size grid, no idling
    calm = 1'b1;
    write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
    write_reg(REG_SECTORS, 16'($urandom_range(1, 200)));
    write_reg(REG_STACKS, 16'($urandom_range(1, 200)));
    add_random(50);
    drain();

    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div.sv
hw/rtl/uvs_sincos.sv
hw/rtl/uvs_vtx.sv
hw/rtl/uv_sphere_cell_vertex_generator.sv
test/tb_top.sv
